### hdl/tlik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlik_pkg;

   // CORDIC iterations of the arctangent unit.
   localparam int CORDIC_STEPS = 16;

   // Field widths at the ports.
   localparam int ANGLE_W  = 17;
   localparam int RADIUS_W = 17;
   localparam int HIP_W    = 18;
   localparam int KNEE_W   = 16;
   localparam int LINK_W   = 16;

   // Widths of the side squares, radicand and root, and the radicand shift.
   localparam int SQ_SHIFT = 26;
   localparam int SQR_W    = 36;
   localparam int RAD_W    = SQR_W + SQ_SHIFT;
   localparam int ROOT_W   = RAD_W / 2;

   // CORDIC datapath: x and y signed with growth headroom, z in 1/32768 degree.
   localparam int CX_W = ROOT_W + 3;
   localparam int Z_W  = 25;
   localparam logic signed [Z_W-1:0] QUARTER_FINE = 25'sd2949120;
   localparam int FINE_SHIFT = 7;
   localparam logic [Z_W-1:0] FINE_ROUND = 25'd64;

   // Turn constants in 1/128 degree.
   localparam int HALF_TURN = 23040;
   localparam int FULL_TURN = 46080;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_UPPER_LINK = 2'd0,
      CSR_LOWER_LINK = 2'd1,
      CSR_ELBOW_MODE = 2'd2,
      CSR_CLAMP      = 2'd3
   } csr_index_type;

   // Elbow mode codes; the unused code behaves as automatic.
   localparam logic [1:0] ELBOW_AUTO = 2'd0;
   localparam logic [1:0] ELBOW_UP   = 2'd1;
   localparam logic [1:0] ELBOW_DOWN = 2'd2;

   // Item context that travels alongside the arithmetic.
   typedef struct packed {
      logic                       bad;
      logic                       rzero;
      logic                       reach;
      logic                       ok;
      logic                       prev_valid;
      logic signed [ANGLE_W-1:0]  angle;
      logic signed [HIP_W-1:0]    prev_hip;
      logic signed [KNEE_W-1:0]   prev_knee;
   } side_type;

   // Arctangent of 2^-i in 1/32768 degree, rounded to nearest.
   function automatic logic signed [Z_W-1:0] atan_fine(input int idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         0:  v = 25'sd1474560;
         1:  v = 25'sd870484;
         2:  v = 25'sd459940;
         3:  v = 25'sd233473;
         4:  v = 25'sd117189;
         5:  v = 25'sd58652;
         6:  v = 25'sd29333;
         7:  v = 25'sd14667;
         8:  v = 25'sd7334;
         9:  v = 25'sd3667;
         10: v = 25'sd1833;
         11: v = 25'sd917;
         12: v = 25'sd458;
         13: v = 25'sd229;
         14: v = 25'sd115;
         15: v = 25'sd57;
         16: v = 25'sd29;
         17: v = 25'sd14;
         18: v = 25'sd7;
         19: v = 25'sd4;
         20: v = 25'sd2;
         21: v = 25'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### hdl/tlik_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined floor square root, one root bit per stage.
module tlik_sqrt import tlik_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  rad,
   output logic [ROOT_W-1:0] root
);

   logic [ROOT_W+1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rest_ff [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [ROOT_W+1:0] rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rest_prev;
      logic [ROOT_W+3:0] part;
      logic [ROOT_W+3:0] trial;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rest_prev = rad;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign rest_prev = rest_ff[s-1];
      end

      // Bring down the next two radicand bits and try a one digit.
      assign part  = {rem_prev, rest_prev[RAD_W-1 -: 2]};
      assign trial = {2'b00, root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            rest_ff[s] <= {rest_prev[RAD_W-3:0], 2'b00};
            if (part >= trial) begin
               rem_ff[s]  <= (ROOT_W+2)'(part - trial);
               root_ff[s] <= {root_prev[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[s]  <= part[ROOT_W+1:0];
               root_ff[s] <= {root_prev[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

`default_nettype wire

### hdl/tlik_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined vectoring CORDIC giving atan2(y, x), one iteration per stage.
module tlik_cordic import tlik_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ROOT_W-1:0]     x0,
   input  logic [ROOT_W-1:0]     y0,
   output logic signed [Z_W-1:0] z
);

   logic signed [CX_W-1:0] x_ff [CORDIC_STEPS];
   logic signed [CX_W-1:0] y_ff [CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CX_W-1:0] x_prev;
      logic signed [CX_W-1:0] y_prev;
      logic signed [Z_W-1:0]  z_prev;
      logic signed [CX_W-1:0] dx;
      logic signed [CX_W-1:0] dy;

      if (i == 0) begin : g_first
         assign x_prev = signed'({{(CX_W-ROOT_W){1'b0}}, x0});
         assign y_prev = signed'({{(CX_W-ROOT_W){1'b0}}, y0});
         assign z_prev = '0;
      end else begin : g_next
         assign x_prev = x_ff[i-1];
         assign y_prev = y_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      // Arithmetic shifts round toward minus infinity.
      assign dx = y_prev >>> i;
      assign dy = x_prev >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (y_prev > 0) begin
               x_ff[i] <= x_prev + dx;
               y_ff[i] <= y_prev - dy;
               z_ff[i] <= z_prev + atan_fine(i);
            end else begin
               x_ff[i] <= x_prev - dx;
               y_ff[i] <= y_prev + dy;
               z_ff[i] <= z_prev - atan_fine(i);
            end
         end
      end
   end

   assign z = z_ff[CORDIC_STEPS-1];

endmodule

`default_nettype wire

### hdl/tlik_select.sv
`timescale 1ns / 1ps
`default_nettype none

// Rounds the two joint angles, builds both solutions and picks one.
module tlik_select import tlik_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  side_type                side_in,
   input  logic signed [Z_W-1:0]   kap_z,
   input  logic signed [Z_W-1:0]   beta_z,
   input  logic [1:0]              elbow_mode,
   output logic [HIP_W-1:0]        hip,
   output logic [KNEE_W-1:0]       knee,
   output logic                    reach,
   output logic                    bad
);

   localparam int HC_W = HIP_W + 1;
   localparam int D_W  = HC_W + 2;
   localparam int T_W  = D_W + 2;
   localparam int P_W  = 2 * KNEE_W;

   // Wrap an angle difference into one turn centred on zero.
   function automatic logic signed [KNEE_W-1:0] wrap(input logic signed [D_W-1:0] d);
      logic signed [T_W-1:0] t;
      logic signed [T_W-1:0] c;
      logic signed [T_W-1:0] m;
      t = T_W'(d) + T_W'(HALF_TURN);
      m = '0;
      for (int k = -6; k <= 6; k++) begin
         c = t - T_W'(k * FULL_TURN);
         if (c >= 0 && c < T_W'(FULL_TURN)) begin
            m = c;
         end
      end
      return KNEE_W'(m - T_W'(HALF_TURN));
   endfunction

   // Saturate the half angle, round it to 1/256 degree (full angle 1/128).
   function automatic logic [KNEE_W-1:0] round_angle(input logic signed [Z_W-1:0] z);
      logic signed [Z_W-1:0] s;
      logic [Z_W-1:0]        r;
      s = z;
      if (z < 0) begin
         s = '0;
      end else if (z > QUARTER_FINE) begin
         s = QUARTER_FINE;
      end
      r = unsigned'(s) + FINE_ROUND;
      return r[FINE_SHIFT +: KNEE_W];
   endfunction

   side_type                 side1_ff, side2_ff, side3_ff;
   logic                     auto1_ff, auto2_ff, auto3_ff;
   logic                     down1_ff, down2_ff, down3_ff;
   logic [KNEE_W-1:0]        kap1_ff;
   logic signed [HC_W-1:0]   h0_1_ff, h1_1_ff;
   logic signed [HC_W-1:0]   h0_2_ff, h1_2_ff, h0_3_ff, h1_3_ff;
   logic signed [KNEE_W-1:0] k0_2_ff, k1_2_ff, k0_3_ff, k1_3_ff;
   logic signed [KNEE_W-1:0] dh0_ff, dk0_ff, dh1_ff, dk1_ff;
   logic [P_W-1:0]           ph0_ff, pk0_ff, ph1_ff, pk1_ff;
   logic [HIP_W-1:0]         hip_ff;
   logic [KNEE_W-1:0]        knee_ff;
   logic                     reach_ff, bad_ff;

   logic [KNEE_W-1:0]        kap_in, beta_in;
   logic signed [HC_W-1:0]   ang_ext;
   logic signed [KNEE_W-1:0] k0_in, k1_in;
   logic signed [P_W-1:0]    sq_h0, sq_k0, sq_h1, sq_k1;
   logic [P_W:0]             sum0, sum1;
   logic                     down_in;
   logic signed [HC_W-1:0]   hsel;
   logic signed [KNEE_W-1:0] ksel;

   assign kap_in  = round_angle(kap_z);
   assign beta_in = round_angle(beta_z);
   assign ang_ext = HC_W'(side_in.angle);
   assign k0_in   = signed'(kap1_ff);
   assign k1_in   = -signed'(kap1_ff);

   // Stage one: round angles, form both hip candidates and decide the mode.
   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side_in;
         kap1_ff  <= kap_in;
         h0_1_ff  <= ang_ext - signed'(HC_W'(beta_in));
         h1_1_ff  <= ang_ext + signed'(HC_W'(beta_in));
         down1_ff <= (elbow_mode == ELBOW_DOWN);
         auto1_ff <= (elbow_mode != ELBOW_UP) && (elbow_mode != ELBOW_DOWN) &&
                     side_in.prev_valid;
      end
   end

   // Stage two: wrapped distances to the previous pose.
   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side1_ff;
         down2_ff <= down1_ff;
         auto2_ff <= auto1_ff;
         h0_2_ff  <= h0_1_ff;
         h1_2_ff  <= h1_1_ff;
         k0_2_ff  <= k0_in;
         k1_2_ff  <= k1_in;
         dh0_ff   <= wrap(D_W'(h0_1_ff) - D_W'(side1_ff.prev_hip));
         dh1_ff   <= wrap(D_W'(h1_1_ff) - D_W'(side1_ff.prev_hip));
         dk0_ff   <= wrap(D_W'(k0_in) - D_W'(side1_ff.prev_knee));
         dk1_ff   <= wrap(D_W'(k1_in) - D_W'(side1_ff.prev_knee));
      end
   end

   // Stage three: squared distances, formed at full product width.
   assign sq_h0 = dh0_ff * dh0_ff;
   assign sq_k0 = dk0_ff * dk0_ff;
   assign sq_h1 = dh1_ff * dh1_ff;
   assign sq_k1 = dk1_ff * dk1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         side3_ff <= side2_ff;
         down3_ff <= down2_ff;
         auto3_ff <= auto2_ff;
         h0_3_ff  <= h0_2_ff;
         h1_3_ff  <= h1_2_ff;
         k0_3_ff  <= k0_2_ff;
         k1_3_ff  <= k1_2_ff;
         ph0_ff   <= unsigned'(sq_h0);
         pk0_ff   <= unsigned'(sq_k0);
         ph1_ff   <= unsigned'(sq_h1);
         pk1_ff   <= unsigned'(sq_k1);
      end
   end

   // Stage four: compare, select and apply the special cases.
   assign sum0    = (P_W+1)'(ph0_ff) + (P_W+1)'(pk0_ff);
   assign sum1    = (P_W+1)'(ph1_ff) + (P_W+1)'(pk1_ff);
   assign down_in = down3_ff || (auto3_ff && (sum1 < sum0));
   assign hsel    = down_in ? h1_3_ff : h0_3_ff;
   assign ksel    = down_in ? k1_3_ff : k0_3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         bad_ff <= side3_ff.bad;
         if (side3_ff.bad) begin
            hip_ff   <= '0;
            knee_ff  <= '0;
            reach_ff <= 1'b0;
         end else if (side3_ff.rzero) begin
            hip_ff   <= HIP_W'(side3_ff.angle);
            knee_ff  <= '0;
            reach_ff <= 1'b1;
         end else if (!side3_ff.ok) begin
            hip_ff   <= '0;
            knee_ff  <= '0;
            reach_ff <= 1'b0;
         end else begin
            hip_ff   <= hsel[HIP_W-1:0];
            knee_ff  <= ksel;
            reach_ff <= side3_ff.reach;
         end
      end
   end

   assign hip   = hip_ff;
   assign knee  = knee_ff;
   assign reach = reach_ff;
   assign bad   = bad_ff;

endmodule

`default_nettype wire

### hdl/two_link_inverse_kinematics.sv
// From input transfer to result, an item passes the input stages, the pipelined
// square root and CORDIC stage chains, and the solution selection stages.
// Throughput: one item per cycle while the output is not stalled; every stage
// advances whenever the result register is empty or its transfer completes.
// Reset (synchronous, active high) empties the pipeline and loads link lengths
// 256 and 256, automatic elbow mode and rejection of unreachable targets.
`timescale 1ns / 1ps
`default_nettype none

module two_link_inverse_kinematics import tlik_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // target_angle[16:0], target_radius[33:17], prev_hip[51:34], prev_knee[67:52]
   input  logic [71:0] req_tdata,
   // prev_valid[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // hip_angle[17:0], knee_angle[33:18]
   output logic [39:0] rsp_tdata,
   // reachable[0], bad_links[1]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int DLY_LEN  = ROOT_W + CORDIC_STEPS;
   localparam int PIPE_LEN = 3 + DLY_LEN + 4;

   logic [LINK_W-1:0] upper_ff, lower_ff;
   logic [1:0]        elbow_ff;
   logic              clamp_ff;

   logic                adv;
   logic [PIPE_LEN-1:0] valid_ff;

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= LINK_W'(256);
         lower_ff <= LINK_W'(256);
         elbow_ff <= ELBOW_AUTO;
         clamp_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_UPPER_LINK: upper_ff <= csr_data;
            CSR_LOWER_LINK: lower_ff <= csr_data;
            CSR_ELBOW_MODE: elbow_ff <= csr_data[1:0];
            CSR_CLAMP:      clamp_ff <= csr_data[0];
            default:        clamp_ff <= clamp_ff;
         endcase
      end
   end

   // The whole pipeline moves as one whenever the result register can move.
   assign adv        = !valid_ff[PIPE_LEN-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[PIPE_LEN-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[PIPE_LEN-2:0], req_tvalid};
      end
   end

   // Stage one: range checks and clamping of the radius.
   logic [RADIUS_W-1:0] r_raw, maxr, rc_in, rc_ff, maxr_ff;
   logic [LINK_W-1:0]   minr, minr_ff, l1_ff, l2_ff;
   side_type            side_in, side1_ff, side2_ff, side3_ff;

   assign r_raw = req_tdata[33:17];
   assign maxr  = RADIUS_W'(upper_ff) + RADIUS_W'(lower_ff);
   assign minr  = (upper_ff > lower_ff) ? upper_ff - lower_ff : lower_ff - upper_ff;

   always_comb begin
      side_in.bad        = (upper_ff == '0) || (lower_ff == '0);
      side_in.rzero      = (r_raw == '0);
      side_in.reach      = 1'b1;
      side_in.ok         = 1'b1;
      side_in.prev_valid = req_tuser[0];
      side_in.angle      = signed'(req_tdata[16:0]);
      side_in.prev_hip   = signed'(req_tdata[51:34]);
      side_in.prev_knee  = signed'(req_tdata[67:52]);
      rc_in              = r_raw;
      if (r_raw > maxr) begin
         side_in.reach = 1'b0;
         side_in.ok    = clamp_ff;
         rc_in         = maxr;
      end else if (r_raw < RADIUS_W'(minr)) begin
         side_in.reach = 1'b0;
         side_in.ok    = clamp_ff;
         rc_in         = RADIUS_W'(minr);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff <= side_in;
         rc_ff    <= rc_in;
         maxr_ff  <= maxr;
         minr_ff  <= minr;
         l1_ff    <= upper_ff;
         l2_ff    <= lower_ff;
      end
   end

   // Stage two: the six squares of the two triangles, at full product width.
   logic signed [RADIUS_W:0]     diff1;
   logic [RADIUS_W:0]            sum1;
   logic [2*RADIUS_W-1:0]        mul_max, mul_r;
   logic [2*LINK_W-1:0]          mul_min, mul_l2;
   logic signed [2*RADIUS_W+1:0] mul_d;
   logic [2*RADIUS_W+1:0]        mul_s;
   logic [SQR_W-1:0]             sq_max_ff, sq_r_ff, sq_min_ff, sq_l2_ff, sq_d_ff, sq_s_ff;

   assign diff1   = signed'((RADIUS_W+1)'(l1_ff)) - signed'((RADIUS_W+1)'(rc_ff));
   assign sum1    = (RADIUS_W+1)'(l1_ff) + (RADIUS_W+1)'(rc_ff);
   assign mul_max = maxr_ff * maxr_ff;
   assign mul_r   = rc_ff * rc_ff;
   assign mul_min = minr_ff * minr_ff;
   assign mul_l2  = l2_ff * l2_ff;
   assign mul_d   = diff1 * diff1;
   assign mul_s   = sum1 * sum1;

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff  <= side1_ff;
         sq_max_ff <= SQR_W'(mul_max);
         sq_r_ff   <= SQR_W'(mul_r);
         sq_min_ff <= SQR_W'(mul_min);
         sq_l2_ff  <= SQR_W'(mul_l2);
         sq_d_ff   <= unsigned'(mul_d);
         sq_s_ff   <= mul_s;
      end
   end

   // Stage three: half-angle numerators and denominators, negatives held at zero.
   logic signed [SQR_W:0] qk, pk, qb, pb;
   logic [SQR_W-1:0]      qk_ff, pk_ff, qb_ff, pb_ff;

   assign qk = signed'({1'b0, sq_max_ff}) - signed'({1'b0, sq_r_ff});
   assign pk = signed'({1'b0, sq_r_ff})   - signed'({1'b0, sq_min_ff});
   assign qb = signed'({1'b0, sq_l2_ff})  - signed'({1'b0, sq_d_ff});
   assign pb = signed'({1'b0, sq_s_ff})   - signed'({1'b0, sq_l2_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         side3_ff <= side2_ff;
         qk_ff    <= qk[SQR_W] ? '0 : qk[SQR_W-1:0];
         pk_ff    <= pk[SQR_W] ? '0 : pk[SQR_W-1:0];
         qb_ff    <= qb[SQR_W] ? '0 : qb[SQR_W-1:0];
         pb_ff    <= pb[SQR_W] ? '0 : pb[SQR_W-1:0];
      end
   end

   // Square roots of the scaled terms, then the two arctangents.
   logic [ROOT_W-1:0]     rqk, rpk, rqb, rpb;
   logic signed [Z_W-1:0] kap_z, beta_z;

   tlik_sqrt u_sqrt_qk (.clock(clock), .en(adv), .rad({qk_ff, {SQ_SHIFT{1'b0}}}), .root(rqk));
   tlik_sqrt u_sqrt_pk (.clock(clock), .en(adv), .rad({pk_ff, {SQ_SHIFT{1'b0}}}), .root(rpk));
   tlik_sqrt u_sqrt_qb (.clock(clock), .en(adv), .rad({qb_ff, {SQ_SHIFT{1'b0}}}), .root(rqb));
   tlik_sqrt u_sqrt_pb (.clock(clock), .en(adv), .rad({pb_ff, {SQ_SHIFT{1'b0}}}), .root(rpb));

   tlik_cordic u_cordic_kap  (.clock(clock), .en(adv), .x0(rpk), .y0(rqk), .z(kap_z));
   tlik_cordic u_cordic_beta (.clock(clock), .en(adv), .x0(rpb), .y0(rqb), .z(beta_z));

   // Item context follows the arithmetic through the root and CORDIC stages.
   side_type dly_ff [DLY_LEN];

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= side3_ff;
         for (int i = 1; i < DLY_LEN; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   // Solution choice and the result register.
   logic [HIP_W-1:0]  hip;
   logic [KNEE_W-1:0] knee;
   logic              reach, bad;

   tlik_select u_select (
      .clock     (clock),
      .en        (adv),
      .side_in   (dly_ff[DLY_LEN-1]),
      .kap_z     (kap_z),
      .beta_z    (beta_z),
      .elbow_mode(elbow_ff),
      .hip       (hip),
      .knee      (knee),
      .reach     (reach),
      .bad       (bad)
   );

   assign rsp_tdata = {6'b0, knee, hip};
   assign rsp_tuser = {bad, reach};

endmodule

`default_nettype wire
